### design/hsa_pkg.sv
package hsa_pkg;

   localparam int DIV_STEPS = 3;
   localparam int DIV_STAGES = 6;
   localparam int DIV_Q_W = DIV_STEPS * DIV_STAGES;
   localparam int DIV_N_W = DIV_Q_W + 8;
   localparam int SAT_STAGES = 4;
   localparam int RGB_STAGES = 6;
   localparam int LATENCY = 2 + DIV_STAGES + SAT_STAGES + RGB_STAGES;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-3:0] REG_SAT_AMOUNT = '0;

   typedef enum logic [1:0] {
      HUE_RED,
      HUE_GREEN,
      HUE_BLUE
   } hue_sel_type;

   typedef enum logic [2:0] {
      SEC_RED_YEL,
      SEC_YEL_GRN,
      SEC_GRN_CYN,
      SEC_CYN_BLU,
      SEC_BLU_MAG,
      SEC_MAG_RED
   } sector_type;

   typedef struct packed {
      logic [8:0]  sum;
      logic [7:0]  denom;
      logic        neg;
      hue_sel_type hsel;
      logic        gray;
      logic        eof;
   } front_type;

   typedef struct packed {
      logic [8:0]  sum;
      logic [7:0]  denom;
      logic [14:0] h64;
      logic        eof;
   } side_type;

endpackage

### design/hsl_saturation_adjust.sv
// Path: input regs, dividers, hue regs, saturation stages, RGB stages, output register.
// Throughput: one pixel per cycle unless stalled; both 18-step dividers have six stages.
// Output and skid registers hold two results under back pressure; then req_tready drops.
// Reset is synchronous and active high; it clears all valid bits and sat_amount to zero.
module hsl_saturation_adjust import hsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // red_in, green_in, blue_in
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // red_out, green_out, blue_out
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic        en;
   logic        csr_hit;
   logic [15:0] sat_amount_ff, sat_amount_in;

   logic [7:0]  red, green, blue, mx, mn, delta, num_abs;
   logic [8:0]  sum, denom_w, diff, diff_abs;
   logic [19:0] tnum;
   front_type   front_in, front_ff;
   logic [DIV_N_W-1:0] sdiv_ff, sdiv_in, tdiv_ff, tdiv_in;
   logic [7:0]  delta_ff;
   front_type   div_side_ff [DIV_STAGES];
   logic [DIV_Q_W-1:0] q_sat, q_hue;

   front_type   side;
   logic [14:0] hue_t, hue_base, h64;
   logic [16:0] sat_s_ff, sat_s_in;
   side_type    hue_side_ff, hue_side_in;

   logic signed [17:0] sat_adj;
   side_type    sat_side;
   logic [7:0]  red_o, green_o, blue_o;
   logic        eof_o;

   logic [LATENCY-1:0] valid_ff;
   logic [24:0] pipe_data;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [24:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign csr_pready = 1'b1;
   assign csr_hit = csr_paddr[CSR_ADDR_W-1:2] == REG_SAT_AMOUNT;
   assign csr_prdata = csr_hit ? {{16{sat_amount_ff[15]}}, sat_amount_ff} : 32'd0;

   always_comb begin
      sat_amount_in = sat_amount_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         sat_amount_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      red = req_tdata[7:0];
      green = req_tdata[15:8];
      blue = req_tdata[23:16];
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      denom_w = (sum <= 9'd255) ? sum : 9'd510 - sum;
      if (red == mx) begin
         diff = {1'b0, green} - {1'b0, blue};
         front_in.hsel = HUE_RED;
      end else if (green == mx) begin
         diff = {1'b0, blue} - {1'b0, red};
         front_in.hsel = HUE_GREEN;
      end else begin
         diff = {1'b0, red} - {1'b0, green};
         front_in.hsel = HUE_BLUE;
      end
      diff_abs = diff[8] ? 9'd0 - diff : diff;
      num_abs = diff_abs[7:0];
      tnum = {num_abs, 12'b0} - {4'b0, num_abs, 8'b0};
      front_in.sum = sum;
      front_in.denom = denom_w[7:0];
      front_in.neg = diff[8];
      front_in.gray = (delta == 8'd0);
      front_in.eof = req_tlast;
      sdiv_in = {2'b0, delta, 16'b0};
      tdiv_in = {6'b0, tnum};
   end

   hsa_div u_div_sat (
      .clock    (clock),
      .en       (en),
      .dividend (sdiv_ff),
      .divisor  (front_ff.denom),
      .quotient (q_sat)
   );

   hsa_div u_div_hue (
      .clock    (clock),
      .en       (en),
      .dividend (tdiv_ff),
      .divisor  (delta_ff),
      .quotient (q_hue)
   );

   always_comb begin
      side = div_side_ff[DIV_STAGES-1];
      sat_s_in = side.gray ? 17'd0 : q_sat[16:0];
      hue_t = side.gray ? 15'd0 : {3'b0, q_hue[11:0]};
      case (side.hsel)
         HUE_GREEN: hue_base = 15'd7680;
         HUE_BLUE:  hue_base = 15'd15360;
         default:   hue_base = 15'd0;
      endcase
      if (!side.neg) begin
         h64 = hue_base + hue_t;
      end else if (side.hsel == HUE_RED) begin
         h64 = 15'd23040 - hue_t;
      end else begin
         h64 = hue_base - hue_t;
      end
      hue_side_in.sum = side.sum;
      hue_side_in.denom = side.denom;
      hue_side_in.h64 = h64;
      hue_side_in.eof = side.eof;
   end

   hsa_sat u_sat (
      .clock    (clock),
      .en       (en),
      .sat      (sat_s_ff),
      .amount   (sat_amount_ff),
      .side_in  (hue_side_ff),
      .sat_adj  (sat_adj),
      .side_out (sat_side)
   );

   hsa_rgb u_rgb (
      .clock   (clock),
      .en      (en),
      .sat_adj (sat_adj),
      .side_in (sat_side),
      .red     (red_o),
      .green   (green_o),
      .blue    (blue_o),
      .eof     (eof_o)
   );

   assign en = !skid_valid_ff;
   assign req_tready = en;
   assign pipe_data = {eof_o, blue_o, green_o, red_o};

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = valid_ff[LATENCY-1];
            out_data_in = pipe_data;
         end
      end else if (valid_ff[LATENCY-1] && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_amount_ff <= 16'd0;
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         sat_amount_ff <= sat_amount_in;
         if (en) begin
            valid_ff <= {valid_ff[LATENCY-2:0], req_tvalid};
         end
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (en) begin
         front_ff <= front_in;
         sdiv_ff <= sdiv_in;
         tdiv_ff <= tdiv_in;
         delta_ff <= delta;
         div_side_ff[0] <= front_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            div_side_ff[i] <= div_side_ff[i-1];
         end
         sat_s_ff <= sat_s_in;
         hue_side_ff <= hue_side_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff[23:0];
   assign rsp_tlast = out_data_ff[24];

endmodule

### design/hsa_div.sv
module hsa_div import hsa_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [7:0]         divisor,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [7:0]         rem_ff  [DIV_STAGES];
   logic [7:0]         rem_in  [DIV_STAGES];
   logic [7:0]         rem_src [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_ff  [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_in  [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_src [DIV_STAGES];
   logic [7:0]         dvs_ff  [DIV_STAGES];
   logic [7:0]         dvs_src [DIV_STAGES];

   always_comb begin
      rem_src[0] = dividend[DIV_N_W-1:DIV_Q_W];
      bits_src[0] = dividend[DIV_Q_W-1:0];
      dvs_src[0] = divisor;
      for (int i = 1; i < DIV_STAGES; i++) begin
         rem_src[i] = rem_ff[i-1];
         bits_src[i] = bits_ff[i-1];
         dvs_src[i] = dvs_ff[i-1];
      end
   end

   always_comb begin
      logic [8:0]         trial;
      logic [7:0]         rem;
      logic [DIV_Q_W-1:0] bits;
      for (int i = 0; i < DIV_STAGES; i++) begin
         rem = rem_src[i];
         bits = bits_src[i];
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem, bits[DIV_Q_W-1]};
            if (trial >= {1'b0, dvs_src[i]}) begin
               trial = trial - {1'b0, dvs_src[i]};
               bits = {bits[DIV_Q_W-2:0], 1'b1};
            end else begin
               bits = {bits[DIV_Q_W-2:0], 1'b0};
            end
            rem = trial[7:0];
         end
         rem_in[i] = rem;
         bits_in[i] = bits;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            bits_ff[i] <= bits_in[i];
            dvs_ff[i] <= dvs_src[i];
         end
      end
   end

   assign quotient = bits_ff[DIV_STAGES-1];

endmodule

### design/hsa_sat.sv
module hsa_sat import hsa_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [16:0]        sat,
   input  logic [15:0]        amount,
   input  side_type           side_in,
   output logic signed [17:0] sat_adj,
   output side_type           side_out
);

   logic        amount_pos;
   logic [15:0] amount_mag;
   logic [23:0] growth_room;
   logic [40:0] grow_prod;
   logic [32:0] shrink_prod;

   logic [40:0]        prod1_ff, prod1_in;
   logic [16:0]        sat1_ff;
   logic [55:0]        prod2_ff, prod2_in;
   logic [16:0]        sat2_ff;
   logic signed [19:0] shrink2_ff, shrink2_in;
   logic [25:0]        x3_ff;
   logic [52:0]        recip_prod;
   logic [18:0]        q3_ff;
   logic [16:0]        sat3_ff;
   logic signed [19:0] shrink3_ff;
   logic signed [17:0] sat_adj_ff, sat_adj_in;
   logic [26:0]        q_times;
   logic [26:0]        rem;
   logic [18:0]        q_fix;
   logic signed [19:0] grown;
   logic signed [19:0] picked;
   side_type           side_ff [SAT_STAGES];

   assign amount_pos = !amount[15] && (amount != 16'd0);
   assign amount_mag = amount[15] ? 16'd0 - amount : amount;

   always_comb begin
      growth_room = 24'd16711680 - {7'b0, sat};
      grow_prod = sat * growth_room;
      shrink_prod = amount_mag * sat;
      prod1_in = amount_pos ? grow_prod : {8'b0, shrink_prod};
   end

   always_comb begin
      prod2_in = prod1_ff * amount[14:0];
      shrink2_in = $signed({3'b0, sat1_ff}) - $signed({2'b0, prod1_ff[31:14]});
   end

   assign recip_prod = prod2_ff[55:30] * 27'd67372036;

   always_comb begin
      q_times = {q3_ff, 8'b0} - {8'b0, q3_ff};
      rem = {1'b0, x3_ff} - q_times;
      q_fix = q3_ff + {18'b0, (rem >= 27'd255)};
      grown = $signed({3'b0, sat3_ff}) + $signed({1'b0, q_fix});
      picked = amount_pos ? grown : shrink3_ff;
      if (picked > 20'sd65536) begin
         sat_adj_in = 18'sd65536;
      end else if (picked < -20'sd65536) begin
         sat_adj_in = -18'sd65536;
      end else begin
         sat_adj_in = picked[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= prod1_in;
         sat1_ff <= sat;
         prod2_ff <= prod2_in;
         sat2_ff <= sat1_ff;
         shrink2_ff <= shrink2_in;
         x3_ff <= prod2_ff[55:30];
         q3_ff <= recip_prod[52:34];
         sat3_ff <= sat2_ff;
         shrink3_ff <= shrink2_ff;
         sat_adj_ff <= sat_adj_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < SAT_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign sat_adj = sat_adj_ff;
   assign side_out = side_ff[SAT_STAGES-1];

endmodule

### design/hsa_rgb.sv
module hsa_rgb import hsa_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [17:0] sat_adj,
   input  side_type           side_in,
   output logic [7:0]         red,
   output logic [7:0]         green,
   output logic [7:0]         blue,
   output logic               eof
);

   sector_type  sector_in;
   logic [14:0] wrap;
   logic [14:0] f;
   logic [11:0] k_in;

   logic signed [26:0] p1_ff, p1_in;
   logic [8:0]         sum1_ff;
   sector_type         sec_ff [3];
   logic [11:0]        k_ff [3];
   logic [RGB_STAGES-1:0] eof_ff;
   logic signed [26:0] base2_ff, base2_in;
   logic signed [26:0] p2_ff;
   logic signed [39:0] b3_ff, b3_in;
   logic signed [39:0] pc3_ff, pc3_in;
   logic signed [39:0] pk3_ff, pk3_in;
   logic signed [40:0] yc, yx, y0;
   logic signed [40:0] y4_ff [3];
   logic signed [40:0] y4_in [3];
   logic [11:0]        z5_ff [3];
   logic [2:0]         bad5_ff, bad5_in;
   logic [24:0]        qz [3];
   logic [7:0]         chan_ff [3];
   logic [7:0]         chan_in [3];

   always_comb begin
      p1_in = sat_adj * $signed({1'b0, side_in.denom});
      if (side_in.h64 >= 15'd19200) begin
         sector_in = SEC_MAG_RED;
      end else if (side_in.h64 >= 15'd15360) begin
         sector_in = SEC_BLU_MAG;
      end else if (side_in.h64 >= 15'd11520) begin
         sector_in = SEC_CYN_BLU;
      end else if (side_in.h64 >= 15'd7680) begin
         sector_in = SEC_GRN_CYN;
      end else if (side_in.h64 >= 15'd3840) begin
         sector_in = SEC_YEL_GRN;
      end else begin
         sector_in = SEC_RED_YEL;
      end
      case (sector_in)
         SEC_RED_YEL, SEC_YEL_GRN: begin
            wrap = 15'd0;
         end
         SEC_GRN_CYN, SEC_CYN_BLU: begin
            wrap = 15'd7680;
         end
         default: begin
            wrap = 15'd15360;
         end
      endcase
      f = side_in.h64 - wrap;
      if (f >= 15'd3840) begin
         k_in = 12'(15'd7680 - f);
      end else begin
         k_in = f[11:0];
      end
   end

   assign base2_in = $signed({2'b0, sum1_ff, 16'b0}) - p1_ff;

   always_comb begin
      b3_in = base2_ff * $signed(13'd3840);
      pc3_in = p2_ff * $signed(14'd7680);
      pk3_in = p2_ff * $signed({1'b0, k_ff[1], 1'b0});
   end

   always_comb begin
      yc = b3_ff + pc3_ff;
      yx = b3_ff + pk3_ff;
      y0 = b3_ff;
      case (sec_ff[2])
         SEC_RED_YEL: begin
            y4_in[0] = yc; y4_in[1] = yx; y4_in[2] = y0;
         end
         SEC_YEL_GRN: begin
            y4_in[0] = yx; y4_in[1] = yc; y4_in[2] = y0;
         end
         SEC_GRN_CYN: begin
            y4_in[0] = y0; y4_in[1] = yc; y4_in[2] = yx;
         end
         SEC_CYN_BLU: begin
            y4_in[0] = y0; y4_in[1] = yx; y4_in[2] = yc;
         end
         SEC_BLU_MAG: begin
            y4_in[0] = yx; y4_in[1] = y0; y4_in[2] = yc;
         end
         default: begin
            y4_in[0] = yc; y4_in[1] = y0; y4_in[2] = yx;
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         bad5_in[c] = y4_ff[c][40] || (y4_ff[c] > 41'sd128345702400);
         qz[c] = z5_ff[c] * 13'd4370;
         chan_in[c] = bad5_ff[c] ? 8'd0 : qz[c][23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         sum1_ff <= side_in.sum;
         sec_ff[0] <= sector_in;
         k_ff[0] <= k_in;
         eof_ff <= {eof_ff[RGB_STAGES-2:0], side_in.eof};
         base2_ff <= base2_in;
         p2_ff <= p1_ff;
         b3_ff <= b3_in;
         pc3_ff <= pc3_in;
         pk3_ff <= pk3_in;
         for (int i = 1; i < 3; i++) begin
            sec_ff[i] <= sec_ff[i-1];
            k_ff[i] <= k_ff[i-1];
         end
         bad5_ff <= bad5_in;
         for (int c = 0; c < 3; c++) begin
            y4_ff[c] <= y4_in[c];
            z5_ff[c] <= y4_ff[c][36:25];
            chan_ff[c] <= chan_in[c];
         end
      end
   end

   assign red = chan_ff[0];
   assign green = chan_ff[1];
   assign blue = chan_ff[2];
   assign eof = eof_ff[RGB_STAGES-1];

endmodule

### design/hsa_checker.sv
module hsa_checker import hsa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [23:0]           req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [23:0]           rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]           csr_pwdata,
   input logic [31:0]           csr_prdata,
   input logic                  csr_pready
);

   logic csr_write;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
      && (csr_paddr[CSR_ADDR_W-1:2] == REG_SAT_AMOUNT);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled while no response is pending");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (csr_paddr[CSR_ADDR_W-1:2] != REG_SAT_AMOUNT)
         || (csr_prdata[15:0] == $past(csr_pwdata[15:0])))
      else $error("sat_amount readback mismatch");

endmodule

bind hsl_saturation_adjust hsa_checker u_checker (.*);
